>>> rtl/twt_pkg.sv
// ============================================================================
// twt_pkg: shared types and constants of the text window terminal
// Item structs, configuration register indexes, reset values and the
// control characters handled by the put path.
// ============================================================================
`default_nettype none

package twt_pkg;

    // cell layout: character in the low byte, style in the high byte
    localparam int CELL_W = 16;

    // width of a computed cell index (screen and window math)
    localparam int IDX_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd5;

    // register reset values
    localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd80;
    localparam logic [5:0] RST_SCREEN_ROWS   = 6'd25;
    localparam logic [6:0] RST_WINDOW_LEFT   = 7'd0;
    localparam logic [4:0] RST_WINDOW_TOP    = 5'd0;
    localparam logic [7:0] RST_WINDOW_WIDTH  = 8'd80;
    localparam logic [5:0] RST_WINDOW_HEIGHT = 6'd25;

    // control characters
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;

    // input item actions
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  char_code;
        logic [7:0]  style;
        logic [11:0] cell_address;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_style;
        logic [7:0] cursor_col;
        logic [5:0] cursor_row;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/twt_ram.sv
// ============================================================================
// twt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module twt_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/text_window_terminal.sv
// ============================================================================
// text_window_terminal: character-cell terminal confined to a screen window
// Put items write characters at the cursor with newline, backspace, wrap and
// scroll; read items return one screen cell. The screen lives in one RAM.
// ============================================================================
// Throughput: one item at a time, input stalled until the result is handed to
//   out_item; a scroll copies each window row up one row and clears the bottom row.
// Reset: the cursor, control and configuration registers reset at once, then a
//   clearing pass writes zero to all MAX_COLS*MAX_ROWS cells (one a cycle) with
//   input stalled.
`default_nettype none

module text_window_terminal #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input items
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire twt_pkg::in_item_t              in_item,
    // result items
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output twt_pkg::out_item_t                  out_item,
    // configuration writes
    input  wire logic                           cfg_write,
    input  wire logic [twt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [twt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = twt_pkg::IDX_W;
    localparam int CW    = twt_pkg::CELL_W;

    // state codes
    localparam int          STATE_W    = 4;
    localparam logic [3:0]  ST_CLEAR   = 4'd0;
    localparam logic [3:0]  ST_IDLE    = 4'd1;
    localparam logic [3:0]  ST_RD_WAIT = 4'd2;
    localparam logic [3:0]  ST_P_MUL   = 4'd3;
    localparam logic [3:0]  ST_P_WR    = 4'd4;
    localparam logic [3:0]  ST_SET_C   = 4'd5;
    localparam logic [3:0]  ST_SET_R   = 4'd6;
    localparam logic [3:0]  ST_SC_MUL  = 4'd7;
    localparam logic [3:0]  ST_SC_BASE = 4'd8;
    localparam logic [3:0]  ST_SC_RD   = 4'd9;
    localparam logic [3:0]  ST_SC_WR   = 4'd10;
    localparam logic [3:0]  ST_CL_MUL  = 4'd11;
    localparam logic [3:0]  ST_CL_BASE = 4'd12;
    localparam logic [3:0]  ST_CL_WR   = 4'd13;
    localparam logic [3:0]  ST_DONE    = 4'd14;

    // configuration registers
    logic [7:0] sw_reg;
    logic [5:0] sr_reg;
    logic [6:0] wl_reg;
    logic [4:0] wt_reg;
    logic [7:0] ww_reg;
    logic [5:0] wh_reg;

    // control and datapath registers
    logic [STATE_W-1:0] state_reg, state_next;
    logic [7:0]         col_reg, col_next;
    logic [5:0]         row_reg, row_next;
    logic               wrap_reg, wrap_next;
    logic [5:0]         i_reg, i_next;
    logic [7:0]         k_reg, k_next;
    logic [6:0]         y_reg, y_next;
    logic [8:0]         x_reg, x_next;
    logic [CW-1:0]      wdata_reg, wdata_next;
    logic [IW-1:0]      sbase_reg, sbase_next;
    logic [IW-1:0]      dbase_reg, dbase_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [7:0]         res_char_reg, res_char_next;
    logic [7:0]         res_style_reg, res_style_next;
    logic               out_valid_reg, out_valid_next;
    twt_pkg::out_item_t out_item_reg, out_item_next;
    logic [14:0]        prod_reg;
    logic [13:0]        limit_reg;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [CW-1:0] ram_rdata;

    // effective window size, zero acts as one
    logic [7:0] effw;
    logic [5:0] effh;
    assign effw = (ww_reg == 8'd0) ? 8'd1 : ww_reg;
    assign effh = (wh_reg == 6'd0) ? 6'd1 : wh_reg;

    // shared row multiplier operand
    logic [6:0]  mul_y;
    logic [14:0] mul_p;

    always_comb
    begin
        priority if (state_reg == ST_SC_MUL)
        begin
            mul_y = 7'(wt_reg) + 7'(i_reg);
        end
        else if (state_reg == ST_CL_MUL)
        begin
            mul_y = 7'(wt_reg) + 7'(effh) - 7'd1;
        end
        else
        begin
            mul_y = y_reg;
        end
    end

    assign mul_p = {8'd0, mul_y} * {7'd0, sw_reg};

    // write and read cell indexes
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] rd_idx;
    logic          wr_ok;
    logic          rd_in_store;

    always_comb
    begin
        unique case (state_reg)
            ST_P_WR:
            begin
                wr_idx = IW'(prod_reg) + IW'(x_reg);
            end
            default:
            begin
                wr_idx = dbase_reg + IW'(k_reg);
            end
        endcase
    end

    assign wr_ok = (wr_idx < IW'(limit_reg)) && (32'(wr_idx) < 32'(DEPTH));

    assign rd_idx = (state_reg == ST_SC_RD) ? (sbase_reg + IW'(k_reg))
                                            : IW'(in_item.cell_address);
    assign rd_in_store = (32'(rd_idx) < 32'(DEPTH));

    // input accepted only when idle
    logic in_fire;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;

    // main sequencer
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        wrap_next      = wrap_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        wdata_next     = wdata_reg;
        sbase_next     = sbase_reg;
        dbase_next     = dbase_reg;
        rd_ok_next     = rd_ok_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_char_next  = res_char_reg;
        res_style_next = res_style_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_idx[AW-1:0];
        ram_wdata      = wdata_reg;
        ram_raddr      = rd_idx[AW-1:0];

        unique case (state_reg)
            // clearing pass after reset
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // take an item
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_char_next  = 8'd0;
                    res_style_next = 8'd0;
                    wrap_next      = 1'b0;
                    y_next         = 7'(wt_reg) + 7'(row_reg);
                    if (in_item.action == twt_pkg::ACT_READ)
                    begin
                        rd_ok_next = rd_in_store;
                        state_next = ST_RD_WAIT;
                    end
                    else if (in_item.char_code == twt_pkg::CH_NEWLINE)
                    begin
                        col_next   = 8'd0;
                        row_next   = row_reg + 6'd1;
                        state_next = ST_SET_C;
                    end
                    else if (in_item.char_code == twt_pkg::CH_BACKSPACE)
                    begin
                        if (col_reg != 8'd0)
                        begin
                            col_next   = col_reg - 8'd1;
                            x_next     = 9'(wl_reg) + 9'(col_reg - 8'd1);
                            wdata_next = {in_item.style, 8'd0};
                            state_next = ST_P_MUL;
                        end
                        else
                        begin
                            state_next = ST_SET_C;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + 8'd1;
                        x_next     = 9'(wl_reg) + 9'(col_reg);
                        wdata_next = {in_item.style, in_item.char_code};
                        state_next = ST_P_MUL;
                    end
                end
            end

            // read data back
            ST_RD_WAIT:
            begin
                res_char_next  = rd_ok_reg ? ram_rdata[7:0] : 8'd0;
                res_style_next = rd_ok_reg ? ram_rdata[15:8] : 8'd0;
                state_next     = ST_DONE;
            end

            // row offset of the put cell
            ST_P_MUL:
            begin
                state_next = ST_P_WR;
            end

            // write the put cell if it is on screen
            ST_P_WR:
            begin
                ram_we     = wr_ok;
                state_next = ST_SET_C;
            end

            // column wrap: repeated subtraction gives column mod width
            ST_SET_C:
            begin
                if (col_reg >= effw)
                begin
                    col_next  = col_reg - effw;
                    wrap_next = 1'b1;
                end
                else
                begin
                    if (wrap_reg)
                    begin
                        row_next = row_reg + 6'd1;
                    end
                    wrap_next  = 1'b0;
                    state_next = ST_SET_R;
                end
            end

            // scroll until the row is inside the window
            ST_SET_R:
            begin
                if (row_reg >= effh)
                begin
                    if (effh > 6'd1)
                    begin
                        i_next     = 6'd1;
                        state_next = ST_SC_MUL;
                    end
                    else
                    begin
                        state_next = ST_CL_MUL;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // source row offset of this scroll row
            ST_SC_MUL:
            begin
                state_next = ST_SC_BASE;
            end

            // source and destination row bases
            ST_SC_BASE:
            begin
                sbase_next = IW'(prod_reg) + IW'(wl_reg);
                dbase_next = IW'(prod_reg) + IW'(wl_reg) - IW'(sw_reg);
                k_next     = 8'd0;
                state_next = ST_SC_RD;
            end

            // read one source cell
            ST_SC_RD:
            begin
                rd_ok_next = rd_in_store;
                state_next = ST_SC_WR;
            end

            // write it one row up
            ST_SC_WR:
            begin
                ram_we    = wr_ok;
                ram_wdata = rd_ok_reg ? ram_rdata : '0;
                if (k_reg == effw - 8'd1)
                begin
                    if (i_reg == effh - 6'd1)
                    begin
                        state_next = ST_CL_MUL;
                    end
                    else
                    begin
                        i_next     = i_reg + 6'd1;
                        state_next = ST_SC_MUL;
                    end
                end
                else
                begin
                    k_next     = k_reg + 8'd1;
                    state_next = ST_SC_RD;
                end
            end

            // bottom row offset
            ST_CL_MUL:
            begin
                state_next = ST_CL_BASE;
            end

            ST_CL_BASE:
            begin
                dbase_next = IW'(prod_reg) + IW'(wl_reg);
                k_next     = 8'd0;
                state_next = ST_CL_WR;
            end

            // clear the bottom row
            ST_CL_WR:
            begin
                ram_we    = wr_ok;
                ram_wdata = '0;
                if (k_reg == effw - 8'd1)
                begin
                    row_next   = row_reg - 6'd1;
                    state_next = ST_SET_R;
                end
                else
                begin
                    k_next = k_reg + 8'd1;
                end
            end

            // hand the result to the output register
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.cell_char  = res_char_reg;
                    out_item_next.cell_style = res_style_reg;
                    out_item_next.cursor_col = 8'({1'b0, wl_reg} + col_reg);
                    out_item_next.cursor_row = 6'({1'b0, wt_reg} + row_reg);
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            col_reg       <= 8'd0;
            row_reg       <= 6'd0;
            wrap_reg      <= 1'b0;
            i_reg         <= 6'd0;
            k_reg         <= 8'd0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            wrap_reg      <= wrap_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        y_reg         <= y_next;
        x_reg         <= x_next;
        wdata_reg     <= wdata_next;
        sbase_reg     <= sbase_next;
        dbase_reg     <= dbase_next;
        rd_ok_reg     <= rd_ok_next;
        res_char_reg  <= res_char_next;
        res_style_reg <= res_style_next;
        out_item_reg  <= out_item_next;
        prod_reg      <= mul_p;
        limit_reg     <= {8'd0, sr_reg} * {6'd0, sw_reg};
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= twt_pkg::RST_SCREEN_WIDTH;
            sr_reg <= twt_pkg::RST_SCREEN_ROWS;
            wl_reg <= twt_pkg::RST_WINDOW_LEFT;
            wt_reg <= twt_pkg::RST_WINDOW_TOP;
            ww_reg <= twt_pkg::RST_WINDOW_WIDTH;
            wh_reg <= twt_pkg::RST_WINDOW_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                twt_pkg::CFG_SCREEN_WIDTH:  sw_reg <= cfg_data;
                twt_pkg::CFG_SCREEN_ROWS:   sr_reg <= cfg_data[5:0];
                twt_pkg::CFG_WINDOW_LEFT:   wl_reg <= cfg_data[6:0];
                twt_pkg::CFG_WINDOW_TOP:    wt_reg <= cfg_data[4:0];
                twt_pkg::CFG_WINDOW_WIDTH:  ww_reg <= cfg_data;
                twt_pkg::CFG_WINDOW_HEIGHT: wh_reg <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    // screen store
    twt_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    // a result only appears from the hand-off state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the hand-off state");

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE) && (state_reg != ST_CLEAR))
        else $error("accepted item did not start work");

    // RAM writes only from write states
    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR) || (state_reg == ST_P_WR) ||
                   (state_reg == ST_SC_WR) || (state_reg == ST_CL_WR))
        else $error("RAM write from an unexpected state");

    // nothing is delivered while the store is being cleared after reset
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result present during clearing pass");
`endif

endmodule

`default_nettype wire
